### src/ppp_ft_pkg.sv
// Shared types, constants and functions of the PPP frame transmitter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ppp_ft_pkg;

   localparam logic [15:0] FCS_SEED = 16'h3C7C;
   localparam logic [15:0] FCS_POLY = 16'h8408;
   localparam logic [15:0] FCS_INV  = 16'hFFFF;
   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [7:0]  XON_BYTE  = 8'h11;
   localparam logic [7:0]  DC2_BYTE  = 8'h12;
   localparam logic [7:0]  XOFF_BYTE = 8'h13;
   localparam logic [7:0]  ADDR_BYTE = 8'hFF;
   localparam logic [7:0]  CTRL_BYTE = 8'h03;
   localparam logic [7:0]  PROT_HI_BYTE = 8'h40;
   localparam logic [7:0]  PROT_LO_BYTE = 8'h41;

   // Depth of the command queue between front and back; a power of two.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_last;
      logic       empty_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_done;
   } rsp_type;

   // One classified request as handed from the front to the back.
   typedef struct packed {
      logic        header;
      logic        has_byte;
      logic [7:0]  payload_byte;
      logic        tail;
      logic [15:0] fcs;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_HDR4,
      PH_DATA,
      PH_FCS_LO,
      PH_FCS_HI,
      PH_FLAG
   } phase_type;

   function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] c;
      c = fcs ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ FCS_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == XON_BYTE) || (b == DC2_BYTE) || (b == XOFF_BYTE) ||
             (b == ESC_BYTE) || (b == FLAG_BYTE);
   endfunction

endpackage

`default_nettype wire

### src/ppp_ft_front.sv
// Front part: accepts requests, tracks frame state and the running FCS,
// and turns each request into a command. Depends on ppp_ft_pkg.
`default_nettype none

module ppp_ft_front
   import ppp_ft_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         q_push,
   output cmd_type      q_data
);

   logic        in_frame_ff, in_frame_in;
   logic [15:0] fcs_ff, fcs_in;
   logic [15:0] fcs_next;
   logic        ends_frame;

   always_comb begin
      q_push     = req_push && !q_full;
      fcs_next   = req_data.empty_frame ? fcs_ff : fcs_update(fcs_ff, req_data.payload_byte);
      ends_frame = req_data.empty_frame || req_data.is_last;

      q_data.header       = !in_frame_ff;
      q_data.has_byte     = !req_data.empty_frame;
      q_data.payload_byte = req_data.payload_byte;
      q_data.tail         = ends_frame;
      q_data.fcs          = fcs_next ^ FCS_INV;

      in_frame_in = in_frame_ff;
      fcs_in      = fcs_ff;
      if (q_push) begin
         if (ends_frame) begin
            in_frame_in = 1'b0;
            fcs_in      = FCS_SEED;
         end else begin
            in_frame_in = 1'b1;
            fcs_in      = fcs_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fcs_ff      <= FCS_SEED;
      end else begin
         in_frame_ff <= in_frame_in;
         fcs_ff      <= fcs_in;
      end
   end

endmodule

`default_nettype wire

### src/ppp_ft_fifo.sv
// Short command queue that decouples the front from the back.
// Depends on ppp_ft_pkg for the command type and the queue depth.
`default_nettype none

module ppp_ft_fifo
   import ppp_ft_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      pop_data
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full     = (count_ff == (QPTR_W + 1)'(QDEPTH));
      empty    = (count_ff == '0);
      pop_data = entry_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;

      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/ppp_ft_back.sv
// Back part: walks each command through its share of header, stuffed payload, FCS
// and closing flag, one line byte per cycle unless stalled. Uses ppp_ft_pkg.
`default_nettype none

module ppp_ft_back
   import ppp_ft_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_data,
   output logic         q_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   cmd_type   cmd_ff, cmd_in;
   logic      cmd_valid_ff, cmd_valid_in;
   phase_type phase_ff, phase_in;
   logic      esc_ff, esc_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff, out_in;

   phase_type next_phase, start_phase;
   logic      cmd_end, step_done, slot_free, fire, load, esc_next;
   logic [7:0] cur_byte, emit_byte;
   logic      emit_flag;

   always_comb begin
      // Source byte of the stuffed phases.
      case (phase_ff)
         PH_DATA:   cur_byte = cmd_ff.payload_byte;
         PH_FCS_LO: cur_byte = cmd_ff.fcs[7:0];
         PH_FCS_HI: cur_byte = cmd_ff.fcs[15:8];
         default:   cur_byte = 8'h00;
      endcase

      emit_flag = 1'b0;
      step_done = 1'b1;
      esc_next  = 1'b0;
      case (phase_ff)
         PH_HDR0: emit_byte = FLAG_BYTE;
         PH_HDR1: emit_byte = ADDR_BYTE;
         PH_HDR2: emit_byte = CTRL_BYTE;
         PH_HDR3: emit_byte = PROT_HI_BYTE;
         PH_HDR4: emit_byte = PROT_LO_BYTE;
         PH_FLAG: begin
            emit_byte = FLAG_BYTE;
            emit_flag = 1'b1;
         end
         PH_DATA, PH_FCS_LO, PH_FCS_HI: begin
            if (!esc_ff && needs_escape(cur_byte)) begin
               emit_byte = ESC_BYTE;
               esc_next  = 1'b1;
               step_done = 1'b0;
            end else if (esc_ff) begin
               emit_byte = cur_byte ^ ESC_XOR;
            end else begin
               emit_byte = cur_byte;
            end
         end
         default: emit_byte = 8'h00;
      endcase

      cmd_end = 1'b0;
      case (phase_ff)
         PH_HDR0: next_phase = PH_HDR1;
         PH_HDR1: next_phase = PH_HDR2;
         PH_HDR2: next_phase = PH_HDR3;
         PH_HDR3: next_phase = PH_HDR4;
         PH_HDR4: next_phase = cmd_ff.has_byte ? PH_DATA : PH_FCS_LO;
         PH_DATA: begin
            next_phase = PH_FCS_LO;
            cmd_end    = !cmd_ff.tail;
         end
         PH_FCS_LO: next_phase = PH_FCS_HI;
         PH_FCS_HI: next_phase = PH_FLAG;
         PH_FLAG: begin
            next_phase = PH_HDR0;
            cmd_end    = 1'b1;
         end
         default: begin
            next_phase = PH_HDR0;
            cmd_end    = 1'b1;
         end
      endcase

      if (q_data.header) begin
         start_phase = PH_HDR0;
      end else if (q_data.has_byte) begin
         start_phase = PH_DATA;
      end else begin
         start_phase = PH_FCS_LO;
      end

      slot_free = !out_valid_ff || rsp_pop;
      fire      = cmd_valid_ff && slot_free;
      load      = !q_empty && (!cmd_valid_ff || (fire && step_done && cmd_end));
      q_pop     = load;

      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      phase_in     = phase_ff;
      esc_in       = esc_ff;
      if (fire) begin
         esc_in = esc_next;
         if (step_done) begin
            if (cmd_end) begin
               cmd_valid_in = 1'b0;
            end else begin
               phase_in = next_phase;
            end
         end
      end
      if (load) begin
         cmd_in       = q_data;
         cmd_valid_in = 1'b1;
         phase_in     = start_phase;
         esc_in       = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_in.line_byte  = emit_byte;
         out_in.run_last   = step_done && cmd_end;
         out_in.frame_done = emit_flag;
         out_valid_in      = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR0;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

### src/ppp_frame_transmitter_unit.sv
// Top level of the PPP frame transmitter: front, command queue and back.
// Depends on ppp_ft_pkg, ppp_ft_front, ppp_ft_fifo and ppp_ft_back.
//
//   channel   direction  ports                           accepted when
//   request   in         req_push, req_full, req_data    req_push && !req_full
//   result    out        rsp_empty, rsp_pop, rsp_data    rsp_pop && !rsp_empty
//
// The back emits one line byte per cycle while not stalled. A request yields
// 1 or 2 line bytes for a payload byte, plus 5 for a header and 3 to 5
// for FCS and closing flag at frame end. The front takes a request every cycle
// while the four-entry command queue has room. A stalled result holds the back;
// reset empties the queue and returns to the between-frames state.
`default_nettype none

module ppp_frame_transmitter_unit
   import ppp_ft_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wr_data, q_rd_data;

   assign req_full = q_full;

   ppp_ft_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   ppp_ft_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rd_data)
   );

   ppp_ft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
